// File: rtl/core/pri_pkg.sv
// Shared types and codes for the pump run interlock.
package pri_pkg;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_START = 2'd1,
		MODE_ABORT = 2'd2,
		MODE_ESTOP = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BUSY     = 3'd1,
		ST_BAD_DUR  = 3'd2,
		ST_TOO_SOON = 3'd3,
		ST_HOUR_QTA = 3'd4,
		ST_DAY_QTA  = 3'd5,
		ST_TANK     = 3'd6,
		ST_SOIL_WET = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE      = 2'd0,
		EV_STARTED   = 2'd1,
		EV_COMPLETED = 2'd2,
		EV_ABORTED   = 2'd3
	} event_t;

	typedef enum logic [2:0] {
		REG_MAX_RUN   = 3'd0,
		REG_MIN_GAP   = 3'd1,
		REG_HOUR_QTA  = 3'd2,
		REG_DAY_QTA   = 3'd3,
		REG_WET_THR   = 3'd4,
		REG_DRIVE_POL = 3'd5
	} reg_idx_t;

	localparam int unsigned CFG_DATA_W = 27;

	typedef struct packed {
		logic [19:0] max_run_ms;
		logic [26:0] min_gap_ms;
		logic [21:0] hour_quota_ms;
		logic [26:0] day_quota_ms;
		logic [9:0]  wet_threshold;
		logic        drive_active_high;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [19:0] run_ms;
		logic        tank_empty;
		logic        soil_ok;
		logic [9:0]  soil_level;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        pin_level;
		logic        is_running;
		logic [1:0]  event_kind;
		logic [19:0] event_ms;
	} result_t;

endpackage

// File: rtl/core/pump_run_interlock_core.sv
// Top level of the pump run interlock: input register, interlock update, result register.
//
// Pump safety interlock. Every request is a 1 ms tick, a start, an abort or an
// emergency stop, and every request produces exactly one result. A new request
// is taken every clock cycle unless a stalled result register holds the flow.
// Each request is held in the input register, and the whole update of the
// interlock state happens while it is there, on its way into the result
// register, which drives the outputs. Flow is held only by a stalled result
// register: in_stall rises when the input register is full and the result
// register holds a result that the consumer is stalling. A start request first
// rolls the hour and day windows, then is checked in order: busy, duration, gap
// since the last stop, hourly quota, daily quota, empty reservoir, wet soil. A
// passing start turns the pump on and arms a stop timer that counts ticks; when
// it expires, or an abort arrives while the pump runs, the run time is charged
// to both quotas. An emergency stop only drops the pump output; the timer keeps
// counting and still charges the run, and starts are refused as busy until it
// does. Configuration is written through wr_en/wr_index/wr_data, and the user
// must do so only while the block is idle; the block does not enforce this.
// Indexes 0..5 select max_run_ms, min_gap_ms, hour_quota_ms, day_quota_ms,
// wet_threshold and drive_active_high, others are ignored.
module pump_run_interlock_core #(
	parameter int unsigned HOUR_WINDOW_MS = 3600000,
	parameter int unsigned DAY_WINDOW_MS  = 86400000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            wr_en,
	input  logic [2:0]                      wr_index,
	input  logic [pri_pkg::CFG_DATA_W-1:0] wr_data,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      mode,
	input  logic [19:0]                     run_ms,
	input  logic                            tank_empty,
	input  logic                            soil_ok,
	input  logic [9:0]                      soil_level,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [2:0]                      status,
	output logic                            pin_level,
	output logic                            is_running,
	output logic [1:0]                      event_kind,
	output logic [19:0]                     event_ms
);

	pri_pkg::cfg_t    cfg;
	pri_pkg::item_t   item_s1;
	pri_pkg::result_t res_d;
	pri_pkg::result_t res_q;
	logic             valid_s1;
	logic             out_valid_q;
	logic             in_take;
	logic             advance;

	// the stage moves forward whenever the result register is empty or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	pri_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.mode       <= mode;
			item_s1.run_ms     <= run_ms;
			item_s1.tank_empty <= tank_empty;
			item_s1.soil_ok    <= soil_ok;
			item_s1.soil_level <= soil_level;
		end
	end

	// interlock state update; commits only when the request moves on
	pri_step #(
		.HOUR_WINDOW_MS (HOUR_WINDOW_MS),
		.DAY_WINDOW_MS  (DAY_WINDOW_MS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_q.status;
	assign pin_level  = res_q.pin_level;
	assign is_running = res_q.is_running;
	assign event_kind = res_q.event_kind;
	assign event_ms   = res_q.event_ms;

endmodule

// File: rtl/core/pri_cfg.sv
// Configuration register bank of the pump run interlock.
module pri_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [2:0]                      wr_index,
	input  logic [pri_pkg::CFG_DATA_W-1:0] wr_data,
	output pri_pkg::cfg_t                   cfg
);

	pri_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_run_ms        <= 20'd60000;
			cfg_q.min_gap_ms        <= 27'd300000;
			cfg_q.hour_quota_ms     <= 22'd300000;
			cfg_q.day_quota_ms      <= 27'd1200000;
			cfg_q.wet_threshold     <= 10'd700;
			cfg_q.drive_active_high <= 1'b1;
		end else if (wr_en) begin
			case (pri_pkg::reg_idx_t'(wr_index))
				pri_pkg::REG_MAX_RUN:   cfg_q.max_run_ms        <= wr_data[19:0];
				pri_pkg::REG_MIN_GAP:   cfg_q.min_gap_ms        <= wr_data[26:0];
				pri_pkg::REG_HOUR_QTA:  cfg_q.hour_quota_ms     <= wr_data[21:0];
				pri_pkg::REG_DAY_QTA:   cfg_q.day_quota_ms      <= wr_data[26:0];
				pri_pkg::REG_WET_THR:   cfg_q.wet_threshold     <= wr_data[9:0];
				pri_pkg::REG_DRIVE_POL: cfg_q.drive_active_high <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/pri_step.sv
// Interlock state and the per-request update: checks, run timer, quota accounting.
module pri_step #(
	parameter int unsigned HOUR_WINDOW_MS = 3600000,
	parameter int unsigned DAY_WINDOW_MS  = 86400000
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  pri_pkg::item_t   item,
	input  pri_pkg::cfg_t    cfg,
	output pri_pkg::result_t result
);

	localparam logic [21:0] HourWin = 22'(HOUR_WINDOW_MS);
	localparam logic [26:0] DayWin  = 27'(DAY_WINDOW_MS);

	logic        pump_on_q, stop_armed_q, ever_stopped_q;
	logic [19:0] elapsed_ms_q, target_ms_q;
	logic [26:0] since_stop_ms_q, day_age_ms_q;
	logic [21:0] hour_age_ms_q;
	logic [31:0] hour_used_ms_q, day_used_ms_q;

	logic        pump_on_d, stop_armed_d, ever_stopped_d;
	logic [19:0] elapsed_ms_d, target_ms_d;
	logic [26:0] since_stop_ms_d, day_age_ms_d;
	logic [21:0] hour_age_ms_d;
	logic [31:0] hour_used_ms_d, day_used_ms_d;

	logic        finish;
	logic [19:0] fin_ms;
	logic [19:0] el_inc;
	logic [21:0] ha_roll;
	logic [26:0] da_roll;
	logic [31:0] hu_roll, du_roll;
	logic [32:0] hour_need, day_need, hu_sum, du_sum;
	pri_pkg::status_t st;

	// window roll as seen by a start request
	always_comb begin
		ha_roll = hour_age_ms_q;
		hu_roll = hour_used_ms_q;
		da_roll = day_age_ms_q;
		du_roll = day_used_ms_q;
		if (hour_age_ms_q > HourWin) begin
			ha_roll = '0;
			hu_roll = '0;
		end
		if (day_age_ms_q > DayWin) begin
			da_roll = '0;
			du_roll = '0;
		end
		hour_need = {1'b0, hu_roll} + {13'd0, item.run_ms};
		day_need  = {1'b0, du_roll} + {13'd0, item.run_ms};
	end

	// start checks in priority order
	always_comb begin
		if (stop_armed_q)
			st = pri_pkg::ST_BUSY;
		else if (item.run_ms == '0 || item.run_ms > cfg.max_run_ms)
			st = pri_pkg::ST_BAD_DUR;
		else if (ever_stopped_q && since_stop_ms_q < cfg.min_gap_ms)
			st = pri_pkg::ST_TOO_SOON;
		else if (hour_need > {11'd0, cfg.hour_quota_ms})
			st = pri_pkg::ST_HOUR_QTA;
		else if (day_need > {6'd0, cfg.day_quota_ms})
			st = pri_pkg::ST_DAY_QTA;
		else if (item.tank_empty)
			st = pri_pkg::ST_TANK;
		else if (item.soil_ok && item.soil_level >= cfg.wet_threshold)
			st = pri_pkg::ST_SOIL_WET;
		else
			st = pri_pkg::ST_OK;
	end

	assign el_inc = (&elapsed_ms_q) ? elapsed_ms_q : elapsed_ms_q + 20'd1;

	always_comb begin
		pump_on_d       = pump_on_q;
		stop_armed_d    = stop_armed_q;
		ever_stopped_d  = ever_stopped_q;
		elapsed_ms_d    = elapsed_ms_q;
		target_ms_d     = target_ms_q;
		since_stop_ms_d = since_stop_ms_q;
		hour_age_ms_d   = hour_age_ms_q;
		day_age_ms_d    = day_age_ms_q;
		hour_used_ms_d  = hour_used_ms_q;
		day_used_ms_d   = day_used_ms_q;
		finish          = 1'b0;
		fin_ms          = elapsed_ms_q;
		result.status     = pri_pkg::ST_OK;
		result.event_kind = pri_pkg::EV_NONE;
		result.event_ms   = '0;

		case (pri_pkg::mode_t'(item.mode))
			pri_pkg::MODE_TICK: begin
				since_stop_ms_d = (&since_stop_ms_q) ? since_stop_ms_q : since_stop_ms_q + 27'd1;
				hour_age_ms_d   = (&hour_age_ms_q) ? hour_age_ms_q : hour_age_ms_q + 22'd1;
				day_age_ms_d    = (&day_age_ms_q) ? day_age_ms_q : day_age_ms_q + 27'd1;
				if (stop_armed_q) begin
					elapsed_ms_d = el_inc;
					if (el_inc >= target_ms_q) begin
						finish            = 1'b1;
						fin_ms            = el_inc;
						result.event_kind = pri_pkg::EV_COMPLETED;
						result.event_ms   = el_inc;
					end
				end
			end
			pri_pkg::MODE_START: begin
				hour_age_ms_d  = ha_roll;
				hour_used_ms_d = hu_roll;
				day_age_ms_d   = da_roll;
				day_used_ms_d  = du_roll;
				result.status  = st;
				if (st == pri_pkg::ST_OK) begin
					pump_on_d         = 1'b1;
					stop_armed_d      = 1'b1;
					elapsed_ms_d      = '0;
					target_ms_d       = item.run_ms;
					result.event_kind = pri_pkg::EV_STARTED;
					result.event_ms   = item.run_ms;
				end
			end
			pri_pkg::MODE_ABORT: begin
				if (pump_on_q) begin
					finish            = 1'b1;
					result.event_kind = pri_pkg::EV_ABORTED;
					result.event_ms   = elapsed_ms_q;
				end
			end
			default: begin
				pump_on_d = 1'b0;
			end
		endcase

		// run accounting into both quota windows, saturating
		hu_sum = {1'b0, hour_used_ms_q} + {13'd0, fin_ms};
		du_sum = {1'b0, day_used_ms_q} + {13'd0, fin_ms};
		if (finish) begin
			pump_on_d       = 1'b0;
			stop_armed_d    = 1'b0;
			ever_stopped_d  = 1'b1;
			since_stop_ms_d = '0;
			hour_used_ms_d  = hu_sum[32] ? '1 : hu_sum[31:0];
			day_used_ms_d   = du_sum[32] ? '1 : du_sum[31:0];
		end

		result.is_running = pump_on_d;
		result.pin_level  = cfg.drive_active_high ? pump_on_d : ~pump_on_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pump_on_q       <= 1'b0;
			stop_armed_q    <= 1'b0;
			ever_stopped_q  <= 1'b0;
			elapsed_ms_q    <= '0;
			target_ms_q     <= '0;
			since_stop_ms_q <= '0;
			hour_age_ms_q   <= '0;
			day_age_ms_q    <= '0;
			hour_used_ms_q  <= '0;
			day_used_ms_q   <= '0;
		end else if (fire) begin
			pump_on_q       <= pump_on_d;
			stop_armed_q    <= stop_armed_d;
			ever_stopped_q  <= ever_stopped_d;
			elapsed_ms_q    <= elapsed_ms_d;
			target_ms_q     <= target_ms_d;
			since_stop_ms_q <= since_stop_ms_d;
			hour_age_ms_q   <= hour_age_ms_d;
			day_age_ms_q    <= day_age_ms_d;
			hour_used_ms_q  <= hour_used_ms_d;
			day_used_ms_q   <= day_used_ms_d;
		end
	end

endmodule

// File: verif/pump_run_interlock_checker.sv
// Channel monitor for the pump run interlock: predicts every result and compares it.
module pump_run_interlock_checker
	import pri_pkg::*;
#(
	parameter int unsigned HOUR_WINDOW_MS = 3600000,
	parameter int unsigned DAY_WINDOW_MS  = 86400000
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [2:0]            wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [1:0]            mode,
	input  logic [19:0]           run_ms,
	input  logic                  tank_empty,
	input  logic                  soil_ok,
	input  logic [9:0]            soil_level,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [2:0]            status,
	input  logic                  pin_level,
	input  logic                  is_running,
	input  logic [1:0]            event_kind,
	input  logic [19:0]           event_ms,
	output int                    n_fail,
	output int                    n_pending,
	output int                    n_checked,
	output int                    n_started
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		status_t     status;
		logic        pin_level;
		logic        running;
		event_t      kind;
		logic [19:0] ms;
	} outcome_t;

	cfg_t        cfg;
	logic        pump_on, armed, ever_stopped;
	logic [19:0] elapsed, target;
	logic [26:0] since_stop, day_age;
	logic [21:0] hour_age;
	logic [31:0] hour_used, day_used;
	outcome_t    outcomes_due[$];
	int          fails, checked, started;

	function automatic logic [31:0] add_clamped(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	// run stops: charge the elapsed time to both windows
	function automatic void end_run();
		pump_on = 1'b0;
		armed = 1'b0;
		ever_stopped = 1'b1;
		since_stop = '0;
		hour_used = add_clamped(hour_used, 32'(elapsed));
		day_used = add_clamped(day_used, 32'(elapsed));
	endfunction

	function automatic status_t start_check(item_t it);
		if (hour_age > HOUR_WINDOW_MS) begin
			hour_age = '0;
			hour_used = '0;
		end
		if (day_age > DAY_WINDOW_MS) begin
			day_age = '0;
			day_used = '0;
		end
		if (armed)
			return ST_BUSY;
		if (it.run_ms == '0 || it.run_ms > cfg.max_run_ms)
			return ST_BAD_DUR;
		if (ever_stopped && since_stop < cfg.min_gap_ms)
			return ST_TOO_SOON;
		if (64'(hour_used) + 64'(it.run_ms) > 64'(cfg.hour_quota_ms))
			return ST_HOUR_QTA;
		if (64'(day_used) + 64'(it.run_ms) > 64'(cfg.day_quota_ms))
			return ST_DAY_QTA;
		if (it.tank_empty)
			return ST_TANK;
		if (it.soil_ok && it.soil_level >= cfg.wet_threshold)
			return ST_SOIL_WET;
		pump_on = 1'b1;
		armed = 1'b1;
		elapsed = '0;
		target = it.run_ms;
		return ST_OK;
	endfunction

	function automatic outcome_t interlock_update(item_t it);
		outcome_t o;
		o.status = ST_OK;
		o.kind = EV_NONE;
		o.ms = '0;
		case (mode_t'(it.mode))
		MODE_TICK: begin
			if (since_stop != '1) since_stop++;
			if (hour_age != '1) hour_age++;
			if (day_age != '1) day_age++;
			if (armed) begin
				if (elapsed != '1) elapsed++;
				if (elapsed >= target) begin
					end_run();
					o.kind = EV_COMPLETED;
					o.ms = elapsed;
				end
			end
		end
		MODE_START: begin
			o.status = start_check(it);
			if (o.status == ST_OK) begin
				o.kind = EV_STARTED;
				o.ms = it.run_ms;
			end
		end
		MODE_ABORT: begin
			// ignored unless the pump is actually driven
			if (pump_on) begin
				end_run();
				o.kind = EV_ABORTED;
				o.ms = elapsed;
			end
		end
		default: pump_on = 1'b0;
		endcase
		o.running = pump_on;
		o.pin_level = cfg.drive_active_high ? pump_on : !pump_on;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] seen);
		$display("[%0t] mismatch on %s: expected %0d, got %0d (result %0d)",
			$realtime, what, want, seen, checked);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want_o, next_o;
		item_t    req;
		if (!arst_n) begin
			cfg = '{max_run_ms: 20'd60000, min_gap_ms: 27'd300000,
				hour_quota_ms: 22'd300000, day_quota_ms: 27'd1200000,
				wet_threshold: 10'd700, drive_active_high: 1'b1};
			pump_on = 1'b0;
			armed = 1'b0;
			ever_stopped = 1'b0;
			elapsed = '0;
			target = '0;
			since_stop = '0;
			hour_age = '0;
			day_age = '0;
			hour_used = '0;
			day_used = '0;
			outcomes_due.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					report_mismatch("result with no request outstanding", '0, 32'(status));
				end else begin
					want_o = outcomes_due.pop_front();
					if (status !== want_o.status)
						report_mismatch("status", 32'(want_o.status), 32'(status));
					if (pin_level !== want_o.pin_level)
						report_mismatch("pin_level", 32'(want_o.pin_level), 32'(pin_level));
					if (is_running !== want_o.running)
						report_mismatch("is_running", 32'(want_o.running), 32'(is_running));
					if (event_kind !== want_o.kind)
						report_mismatch("event_kind", 32'(want_o.kind), 32'(event_kind));
					if (event_ms !== want_o.ms)
						report_mismatch("event_ms", 32'(want_o.ms), 32'(event_ms));
					checked++;
				end
			end
			if (in_valid && !in_stall) begin
				req = {mode, run_ms, tank_empty, soil_ok, soil_level};
				next_o = interlock_update(req);
				if (next_o.kind == EV_STARTED) started++;
				outcomes_due.push_back(next_o);
			end
			if (wr_en) begin
				case (wr_index)
				REG_MAX_RUN:   cfg.max_run_ms = wr_data[19:0];
				REG_MIN_GAP:   cfg.min_gap_ms = wr_data[26:0];
				REG_HOUR_QTA:  cfg.hour_quota_ms = wr_data[21:0];
				REG_DAY_QTA:   cfg.day_quota_ms = wr_data[26:0];
				REG_WET_THR:   cfg.wet_threshold = wr_data[9:0];
				REG_DRIVE_POL: cfg.drive_active_high = wr_data[0];
				default: ;
				endcase
			end
		end
		n_fail <= fails;
		n_pending <= outcomes_due.size();
		n_checked <= checked;
		n_started <= started;
	end

endmodule

// File: verif/pump_run_interlock_core_tb.sv
// Testbench top for the pump run interlock: clock, reset, stimulus, idling and verdict.
module pump_run_interlock_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pri_pkg::*;

	// small 1000 ms windows, so a run of about a thousand ticks rolls them
	localparam int unsigned HOUR_WIN = 1000;
	localparam int unsigned DAY_WIN  = 1000;

	// unmapped register indexes: writes there must leave every setting alone
	localparam logic [2:0] IDX_SPARE_LO = 3'd6;
	localparam logic [2:0] IDX_SPARE_HI = 3'd7;

	localparam int N_PHASES       = 7;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES    = 64;   // receiver hold-off under pressure
	localparam int QUIET_LIMIT    = 2000; // cycles with no handshake at all
	localparam int DRAIN_CYCLES   = 8;    // extra wait after the final quiesce
	localparam int IDLE_SPARSE    = 16;
	localparam int IDLE_DENSE     = 74;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  wr_en      = 1'b0;
	logic [2:0]            wr_index   = '0;
	logic [CFG_DATA_W-1:0] wr_data    = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [1:0]            mode       = MODE_TICK;
	logic [19:0]           run_ms     = '0;
	logic                  tank_empty = 1'b0;
	logic                  soil_ok    = 1'b0;
	logic [9:0]            soil_level = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [2:0]            status;
	logic                  pin_level;
	logic                  is_running;
	logic [1:0]            event_kind;
	logic [19:0]           event_ms;

	int n_fail, n_pending, n_checked, n_started;

	int tx_pct = IDLE_SPARSE;  // sender idle chance per cycle, percent
	int rx_pct = IDLE_DENSE;   // receiver stall chance per cycle, percent
	int hold_req = 0;          // bumped by the stimulus to ask for a long hold-off
	int hold_seen = 0;
	int hold_left = 0;
	int n_sent = 0;
	int n_cfgs = 0;

	cfg_t phase_cfg [N_PHASES];
	int   phase_items [N_PHASES] = '{240, 150, 230, 100, 220, 110, 76};

	pump_run_interlock_core #(
		.HOUR_WINDOW_MS(HOUR_WIN),
		.DAY_WINDOW_MS (DAY_WIN)
	) dut (.*);

	pump_run_interlock_checker #(
		.HOUR_WINDOW_MS(HOUR_WIN),
		.DAY_WINDOW_MS (DAY_WIN)
	) u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result side: random stalls, plus one long hold-off on request so the
	// two pipeline registers fill and the block pushes back on its input.
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	// Watchdog: any handshake or register write counts as progress.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] no handshake for %0d cycles, %0d results still owed",
			$realtime, QUIET_LIMIT, n_pending);
		$display("** pump_run_interlock_core: FAILED **");
		$finish;
	end

	function automatic cfg_t settings(int unsigned max_run, gap, hq, dq, wet, drive);
		cfg_t c;
		c.max_run_ms        = 20'(max_run);
		c.min_gap_ms        = 27'(gap);
		c.hour_quota_ms     = 22'(hq);
		c.day_quota_ms      = 27'(dq);
		c.wet_threshold     = 10'(wet);
		c.drive_active_high = 1'(drive);
		return c;
	endfunction

	// Offer one request, with random idle cycles first; returns on the edge
	// where it is taken. Payload holds steady while stalled.
	task automatic send_req(input mode_t m, input logic [19:0] run, input logic empty,
			input logic sok, input logic [9:0] level);
		while ($urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		run_ms     <= run;
		tank_empty <= empty;
		soil_ok    <= sok;
		soil_level <= level;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// Drop valid and wait until every result owed has come back.
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Single register write; wr_en stays high so back-to-back writes need no gap.
	task automatic put_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
	endtask

	// Writes every register; bits above a register's width carry junk that
	// the block must drop. Also pokes both unmapped indexes.
	task automatic load_cfg(input cfg_t c);
		put_reg(REG_MAX_RUN,   {7'($urandom), c.max_run_ms});
		put_reg(REG_MIN_GAP,   c.min_gap_ms);
		put_reg(REG_HOUR_QTA,  {5'($urandom), c.hour_quota_ms});
		put_reg(REG_DAY_QTA,   c.day_quota_ms);
		put_reg(REG_WET_THR,   {17'($urandom), c.wet_threshold});
		put_reg(REG_DRIVE_POL, {26'($urandom), c.drive_active_high});
		put_reg(IDX_SPARE_LO,  27'($urandom));
		put_reg(IDX_SPARE_HI,  27'($urandom));
		wr_en <= 1'b0;
		@(posedge clk);
		n_cfgs++;
	endtask

	// Random request, weighted toward ticks so runs finish and windows age.
	// Most starts are well formed for the current settings so they get past
	// the early checks; the rest hit duration edges or carry raw fields.
	task automatic send_random(input cfg_t c);
		int          pick;
		int unsigned run_cap;
		logic [19:0] run;
		logic [9:0]  level;
		pick = $urandom_range(99);
		if (pick < 82) begin
			send_req(MODE_TICK, 20'($urandom), 1'($urandom), 1'($urandom),
				10'($urandom_range(1000)));
		end else if (pick < 92) begin
			if ($urandom_range(4) != 0) begin
				run_cap = (c.max_run_ms < 20) ? c.max_run_ms : 20;
				run = 20'($urandom_range(run_cap, 1));
				level = (c.wet_threshold == 0) ? 10'd0
					: 10'($urandom_range(c.wet_threshold - 1));
				send_req(MODE_START, run, $urandom_range(9) == 0, 1'($urandom), level);
			end else begin
				case ($urandom_range(3))
				0: run = '0;
				1: run = c.max_run_ms;
				2: run = c.max_run_ms + 20'd1;
				default: run = 20'($urandom);
				endcase
				send_req(MODE_START, run, 1'($urandom), 1'($urandom),
					10'($urandom_range(1000)));
			end
		end else if (pick < 96) begin
			send_req(MODE_ABORT, 20'($urandom), 1'($urandom), 1'($urandom),
				10'($urandom_range(1000)));
		end else begin
			send_req(MODE_ESTOP, 20'($urandom), 1'($urandom), 1'($urandom),
				10'($urandom_range(1000)));
		end
	endtask

	initial begin
		// settings per random phase: max run, gap, hour quota, day quota, wet, polarity
		phase_cfg[0] = settings(25, 3, 120, 400, 600, 1);
		phase_cfg[1] = settings(1, 0, 3600000, 86400000, 0, 0);
		phase_cfg[2] = settings(600000, 6, 60, 150, 1000, 1);
		phase_cfg[3] = settings(30, 86400000, 3600000, 86400000, 300, 0);
		phase_cfg[4] = settings(15, 2, 200, 500, 800, 0);
		phase_cfg[5] = settings(30, 0, 3600000, 0, 500, 1);
		phase_cfg[6] = settings(10, 1, 0, 86400000, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset settings first.
		send_req(MODE_TICK, '0, 1'b0, 1'b0, '0);
		send_req(MODE_ABORT, '1, 1'b1, 1'b1, 10'd1000);          // abort while idle
		send_req(MODE_ESTOP, '1, 1'b1, 1'b1, 10'd1000);          // e-stop while idle
		send_req(MODE_START, 20'd0, 1'b0, 1'b0, '0);             // zero duration
		send_req(MODE_START, 20'd60001, 1'b0, 1'b0, '0);         // just over the limit
		send_req(MODE_START, 20'hFFFFF, 1'b0, 1'b0, '0);         // widest duration
		send_req(MODE_START, 20'd5, 1'b1, 1'b0, '0);             // empty reservoir
		send_req(MODE_START, 20'd5, 1'b0, 1'b1, 10'd1000);       // valid reading, wet
		send_req(MODE_START, 20'd60000, 1'b0, 1'b0, 10'd1000);   // wet but invalid reading
		send_req(MODE_START, 20'd5, 1'b0, 1'b0, '0);             // busy
		send_req(MODE_TICK, '0, 1'b0, 1'b0, '0);
		send_req(MODE_TICK, '0, 1'b0, 1'b0, '0);
		send_req(MODE_ABORT, '0, 1'b0, 1'b0, '0);                // aborted after 2 ms
		send_req(MODE_START, 20'd3, 1'b0, 1'b0, '0);             // inside the stop gap

		// Tight settings, active-low drive: e-stop mid run, quota edges.
		quiesce();
		load_cfg(settings(20, 0, 12, 30, 1000, 0));
		send_req(MODE_START, 20'd4, 1'b0, 1'b1, 10'd999);        // just under wet level
		send_req(MODE_ESTOP, '0, 1'b0, 1'b0, '0);                // pin drops, counter runs on
		send_req(MODE_START, 20'd4, 1'b0, 1'b0, '0);             // still busy
		send_req(MODE_ABORT, '0, 1'b0, 1'b0, '0);                // ignored, pump already off
		repeat (4) send_req(MODE_TICK, '0, 1'b0, 1'b0, '0);      // completes on the 4th
		send_req(MODE_START, 20'd7, 1'b0, 1'b0, '0);             // hour quota exceeded by one
		send_req(MODE_START, 20'd6, 1'b0, 1'b1, 10'd1000);       // fits quota, soil wet

		// Random phases: sender sparse / receiver dense idling, then reversed,
		// then no idling at all with one long receiver hold-off.
		for (int p = 0; p < N_PHASES; p++) begin
			quiesce();
			load_cfg(phase_cfg[p]);
			if (p < 2) begin
				tx_pct = IDLE_SPARSE;
				rx_pct <= IDLE_DENSE;
			end else if (p < 4) begin
				tx_pct = IDLE_DENSE;
				rx_pct <= IDLE_SPARSE;
			end else begin
				tx_pct = 0;
				rx_pct <= 0;
			end
			if (p == PRESSURE_PHASE)
				hold_req <= hold_req + 1;
			repeat (phase_items[p]) send_random(phase_cfg[p]);
		end

		quiesce();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d requests under %0d register settings; %0d starts granted.",
			n_sent, n_cfgs, n_started);
		$display("%0d results compared field by field, %0d mismatches.", n_checked, n_fail);
		if (n_fail == 0) begin
			$display("** pump_run_interlock_core: PASSED **");
		end else begin
			$display("** pump_run_interlock_core: FAILED **");
		end
		$finish;
	end

endmodule
